[sv/first_fit_slot_range_allocator_core_macros.svh]
// Assertion macros used by the allocator datapath.
// Both macros need clk in scope; FFSRA_ASSERT also needs rst_n.
`ifndef FIRST_FIT_SLOT_RANGE_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_SLOT_RANGE_ALLOCATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define FFSRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFSRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFSRA_ASSERT(lbl, prop, msg)
`define FFSRA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[sv/ffsra_pkg.sv]
`timescale 1ns / 1ps
package ffsra_pkg;

  // slots held in one row of the free map memory
  localparam int ROW_W = 8;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] POOL_TARGET = 2'd0;
  localparam logic [1:0] POOL_DEPTH  = 2'd1;
  localparam logic [1:0] POOL_VIEW   = 2'd2;
  localparam logic [1:0] POOL_BAD    = 2'd3;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_FULL    = 3'd2,
    ST_RANGE   = 3'd3,
    ST_DOUBLE  = 3'd4,
    ST_BADPOOL = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PRE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_CHK_RD,
    S_CHK_EV,
    S_MARK_RD,
    S_MARK_WR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic latch;
    logic pre;
    logic scan;
    logic chk;
    logic mark;
    logic done;
  } ffsra_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pre_err;
    logic is_alloc;
    logic found;
    logic dbl;
    logic scan_last;
    logic rng_last;
    logic out_busy;
  } ffsra_sts_t;

endpackage

[sv/first_fit_slot_range_allocator_core.sv]
`timescale 1ns / 1ps
// First-fit slot range allocator over three pools (render target, depth,
// shader view). Each request is one transaction on the in_ channel
// (valid/ready): allocate a run of in_slot_count slots, or free the run at
// in_slot_index. Each request yields exactly one transaction on the out_
// channel carrying status, granted start and the pool's used count.
// Free maps live in one RAM, 8 slots per row, pools stacked by row.
// Requests are handled one at a time, each running through these states:
//   error caught by the up-front checks: the check state, then done;
//   allocate: check, scan rows to a fit or the last row, mark the fit, done;
//   free: check the range rows (ends on a double free), mark them, done.
// Each row visit has a read state and an evaluate or write state, since the
// RAM read is registered.
// After reset the block sweeps every RAM row to all-free, one row per cycle
// (TR + DR + VR rows, 160 with default sizes) with in_ready low.
// A result waits in the output register while out_ready is low; the next
// request is taken once the block is idle again.
module first_fit_slot_range_allocator_core
  import ffsra_pkg::*;
#(
  parameter int TARGET_SLOTS = 128,
  parameter int DEPTH_SLOTS  = 128,
  parameter int VIEW_SLOTS   = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [1:0]  in_heap_select,
  input  logic [9:0]  in_slot_index,
  input  logic [10:0] in_slot_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [9:0]  out_start_slot,
  output logic [10:0] out_used_slots
);

  ffsra_cmd_t cmd;
  ffsra_sts_t sts;

  // sequence the scan, check and mark passes
  ffsra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold the request, free maps, used counters and the result register
  ffsra_dp #(
    .TARGET_SLOTS (TARGET_SLOTS),
    .DEPTH_SLOTS  (DEPTH_SLOTS),
    .VIEW_SLOTS   (VIEW_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_action),
    .in_heap_select (in_heap_select),
    .in_slot_index  (in_slot_index),
    .in_slot_count  (in_slot_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_start_slot (out_start_slot),
    .out_used_slots (out_used_slots)
  );

endmodule

[sv/ffsra_ram.sv]
`timescale 1ns / 1ps
module ffsra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/ffsra_ctrl.sv]
`timescale 1ns / 1ps
module ffsra_ctrl
  import ffsra_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ffsra_sts_t sts,
  output ffsra_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:    if (in_valid) state_nxt = S_PRE;
      S_PRE: begin
        if (sts.pre_err) state_nxt = S_DONE;
        else if (sts.is_alloc) state_nxt = S_SCAN_RD;
        else state_nxt = S_CHK_RD;
      end
      S_SCAN_RD: state_nxt = S_SCAN_EV;
      S_SCAN_EV: begin
        if (sts.found) state_nxt = S_MARK_RD;
        else if (sts.scan_last) state_nxt = S_DONE;
        else state_nxt = S_SCAN_RD;
      end
      S_CHK_RD:  state_nxt = S_CHK_EV;
      S_CHK_EV: begin
        if (sts.dbl) state_nxt = S_DONE;
        else if (sts.rng_last) state_nxt = S_MARK_RD;
        else state_nxt = S_CHK_RD;
      end
      S_MARK_RD: state_nxt = S_MARK_WR;
      S_MARK_WR: state_nxt = sts.rng_last ? S_DONE : S_MARK_RD;
      S_DONE:    if (!sts.out_busy) state_nxt = S_IDLE;
      default:   state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR:   cmd.clr = 1'b1;
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_PRE:     cmd.pre = 1'b1;
      S_SCAN_EV: cmd.scan = 1'b1;
      S_CHK_EV:  cmd.chk = 1'b1;
      S_MARK_WR: cmd.mark = 1'b1;
      S_DONE:    cmd.done = !sts.out_busy;
      default:   cmd = '0;
    endcase
  end

endmodule

[sv/ffsra_dp.sv]
`timescale 1ns / 1ps
`include "first_fit_slot_range_allocator_core_macros.svh"
module ffsra_dp
  import ffsra_pkg::*;
#(
  parameter int TARGET_SLOTS = 128,
  parameter int DEPTH_SLOTS  = 128,
  parameter int VIEW_SLOTS   = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ffsra_cmd_t  cmd,
  output ffsra_sts_t  sts,
  input  logic        in_action,
  input  logic [1:0]  in_heap_select,
  input  logic [9:0]  in_slot_index,
  input  logic [10:0] in_slot_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [9:0]  out_start_slot,
  output logic [10:0] out_used_slots
);

  localparam int TR   = (TARGET_SLOTS + ROW_W - 1) / ROW_W;
  localparam int DR   = (DEPTH_SLOTS + ROW_W - 1) / ROW_W;
  localparam int VR   = (VIEW_SLOTS + ROW_W - 1) / ROW_W;
  localparam int ROWS = TR + DR + VR;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BI   = $clog2(ROW_W);
  localparam int SWR  = $clog2(ROWS * ROW_W + 1);
  localparam int SW   = (SWR > 12) ? SWR : 12;

  logic              act_r;
  logic [1:0]        pool_r;
  logic [SW-1:0]     idx_r, cnt_r;
  logic [SW-1:0]     lo_r, hi_r;
  logic [SW-1:0]     run_len_r, run_start_r;
  logic [AW-1:0]     ptr_r, clr_row_r;
  status_t           st_r;
  logic [SW-1:0]     tgt_used_r, dep_used_r, view_used_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [9:0]        out_start_r;
  logic [10:0]       out_used_r;

  logic [SW-1:0]     size, pre_hi, slot_base, rl, rs, fs, cur_used, new_used;
  logic [AW-1:0]     base, pool_rows, addr;
  logic              fnd, dbl;
  status_t           pre_st;
  logic [ROW_W-1:0]  rdata, wdata, in_rng, fb;
  logic              we;
  logic [AW-1:0]     waddr;

  always_comb begin
    case (pool_r)
      POOL_TARGET: begin
        size = SW'(TARGET_SLOTS); base = '0; pool_rows = AW'(TR);
        cur_used = tgt_used_r;
      end
      POOL_DEPTH: begin
        size = SW'(DEPTH_SLOTS); base = AW'(TR); pool_rows = AW'(DR);
        cur_used = dep_used_r;
      end
      POOL_VIEW: begin
        size = SW'(VIEW_SLOTS); base = AW'(TR + DR); pool_rows = AW'(VR);
        cur_used = view_used_r;
      end
      default: begin
        size = '0; base = '0; pool_rows = AW'(1); cur_used = '0;
      end
    endcase
  end

  assign addr      = base + ptr_r;
  assign slot_base = SW'(ptr_r) << BI;
  assign pre_hi    = idx_r + cnt_r - SW'(1);

  // request screening in check order
  always_comb begin
    if (pool_r == POOL_BAD) pre_st = ST_BADPOOL;
    else if (cnt_r == '0) pre_st = ST_ZERO;
    else if (act_r == ACT_ALLOC && cnt_r > size) pre_st = ST_FULL;
    else if (act_r == ACT_FREE && (idx_r >= size || cnt_r > size - idx_r)) pre_st = ST_RANGE;
    else pre_st = ST_OK;
  end

  // first-fit run tracking across the slots of one row
  always_comb begin
    rl  = run_len_r;
    rs  = run_start_r;
    fnd = 1'b0;
    fs  = '0;
    for (int b = 0; b < ROW_W; b++) begin
      fb[b] = rdata[b] && ((slot_base + SW'(b)) < size);
      if (!fnd) begin
        if (fb[b]) begin
          if (rl == '0) rs = slot_base + SW'(b);
          rl = rl + SW'(1);
        end else begin
          rl = '0;
        end
        if (rl >= cnt_r) begin
          fnd = 1'b1;
          fs  = rs;
        end
      end
    end
  end

  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      in_rng[b] = ((slot_base + SW'(b)) >= lo_r) && ((slot_base + SW'(b)) <= hi_r);
    end
  end

  assign dbl   = |(rdata & in_rng);
  assign wdata = (act_r == ACT_FREE) ? (rdata | in_rng) : (rdata & ~in_rng);

  always_comb begin
    if (act_r == ACT_ALLOC) begin
      new_used = cur_used + cnt_r;
    end else begin
      new_used = (cur_used >= cnt_r) ? cur_used - cnt_r : '0;
    end
  end

  assign we    = cmd.clr | cmd.mark;
  assign waddr = cmd.clr ? clr_row_r : addr;

  ffsra_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd.clr ? {ROW_W{1'b1}} : wdata),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r  <= in_action;
      pool_r <= in_heap_select;
      idx_r  <= SW'(in_slot_index);
      cnt_r  <= SW'(in_slot_count);
    end
    if (cmd.pre) begin
      st_r        <= pre_st;
      run_len_r   <= '0;
      run_start_r <= '0;
      lo_r        <= idx_r;
      hi_r        <= pre_hi;
      ptr_r       <= (act_r == ACT_ALLOC) ? '0 : AW'(idx_r >> BI);
    end
    if (cmd.scan) begin
      run_len_r   <= rl;
      run_start_r <= rs;
      if (fnd) begin
        lo_r  <= fs;
        hi_r  <= fs + cnt_r - SW'(1);
        ptr_r <= AW'(fs >> BI);
      end else if (ptr_r == pool_rows - AW'(1)) begin
        st_r <= ST_FULL;
      end else begin
        ptr_r <= ptr_r + AW'(1);
      end
    end
    if (cmd.chk) begin
      if (dbl) st_r <= ST_DOUBLE;
      else if (ptr_r == AW'(hi_r >> BI)) ptr_r <= AW'(lo_r >> BI);
      else ptr_r <= ptr_r + AW'(1);
    end
    if (cmd.mark) begin
      ptr_r <= ptr_r + AW'(1);
    end
    if (cmd.done) begin
      out_status_r <= st_r;
      out_start_r  <= (st_r == ST_OK && act_r == ACT_ALLOC) ? lo_r[9:0] : '0;
      out_used_r   <= (st_r == ST_OK) ? new_used[10:0] : cur_used[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_row_r   <= '0;
      tgt_used_r  <= '0;
      dep_used_r  <= '0;
      view_used_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr) clr_row_r <= clr_row_r + AW'(1);
      if (cmd.done && st_r == ST_OK) begin
        case (pool_r)
          POOL_TARGET: tgt_used_r  <= new_used;
          POOL_DEPTH:  dep_used_r  <= new_used;
          POOL_VIEW:   view_used_r <= new_used;
          default:     tgt_used_r  <= tgt_used_r;
        endcase
      end
      if (cmd.done) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sts           = '0;
    sts.clr_last  = (clr_row_r == AW'(ROWS - 1));
    sts.pre_err   = (pre_st != ST_OK);
    sts.is_alloc  = (act_r == ACT_ALLOC);
    sts.found     = fnd;
    sts.dbl       = dbl;
    sts.scan_last = (ptr_r == pool_rows - AW'(1));
    sts.rng_last  = (ptr_r == AW'(hi_r >> BI));
    sts.out_busy  = out_valid_r && !out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_start_slot = out_start_r;
  assign out_used_slots = out_used_r;

  `FFSRA_ASSERT(a_done_no_overwrite, cmd.done |-> (!out_valid_r || out_ready),
    "result loaded over an untaken result")
  `FFSRA_ASSERT(a_used_bounded, (tgt_used_r <= SW'(TARGET_SLOTS)) &&
    (dep_used_r <= SW'(DEPTH_SLOTS)) && (view_used_r <= SW'(VIEW_SLOTS)),
    "used count exceeds pool size")
  `FFSRA_ASSERT(a_mark_in_range, cmd.mark |-> (ptr_r >= AW'(lo_r >> BI) &&
    ptr_r <= AW'(hi_r >> BI)), "mark write outside the granted range")
  `FFSRA_ASSERT(a_single_cmd, $onehot0({cmd.clr, cmd.latch, cmd.pre, cmd.scan,
    cmd.chk, cmd.mark, cmd.done}), "more than one datapath command")

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench
  import ffsra_pkg::*;
();

  localparam int TGT_N  = 128;
  localparam int DEP_N  = 128;
  localparam int VIEW_N = 1024;
  localparam int N_RANDOM = 1330;

  typedef struct packed {
    logic        action;
    logic [1:0]  heap_select;
    logic [9:0]  slot_index;
    logic [10:0] slot_count;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  start_slot;
    logic [10:0] used_slots;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic [1:0] in_heap_select = '0;
  logic [9:0] in_slot_index = '0;
  logic [10:0] in_slot_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [9:0] out_start_slot;
  logic [10:0] out_used_slots;

  // Registered copy of the input handshake: high after an accepted request.
  logic in_acc = 1'b0;

  // Mirror of the three free maps (1 = free) and their used counters.
  bit free_map [3][VIEW_N];
  int used_cnt [3];
  int pool_size [3] = '{TGT_N, DEP_N, VIEW_N};

  request_t pending_q[$];
  grant_t   grant_q[$];
  int err_cnt = 0;
  bit stim_done = 1'b0;

  // Burst / gap control for the sender, stall pattern for the receiver.
  int burst_left = 0;
  int gap_left = 0;
  int rx_phase = 0;

  always #5 clk = ~clk;

  first_fit_slot_range_allocator_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_heap_select(in_heap_select),
    .in_slot_index(in_slot_index), .in_slot_count(in_slot_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_start_slot(out_start_slot),
    .out_used_slots(out_used_slots)
  );

  // Compute the expected grant for one request and advance the mirror.
  function automatic grant_t allocate_or_release(request_t r);
    grant_t g;
    int p, sz, run_start, run_len, idx, cnt;
    bit dbl;
    g = '0;
    p = r.heap_select;
    cnt = r.slot_count;
    idx = r.slot_index;
    if (r.heap_select == POOL_BAD) begin
      g.status = ST_BADPOOL;
      return g;
    end
    sz = pool_size[p];
    if (cnt == 0) begin
      g.status = ST_ZERO;
    end else if (r.action == ACT_ALLOC) begin
      g.status = ST_FULL;
      run_start = 0;
      run_len = 0;
      if (cnt <= sz) begin
        for (int i = 0; i < sz; i++) begin
          if (free_map[p][i]) begin
            if (run_len == 0) run_start = i;
            run_len++;
          end else begin
            run_len = 0;
          end
          if (run_len >= cnt) begin
            for (int k = 0; k < cnt; k++) free_map[p][run_start + k] = 1'b0;
            used_cnt[p] += cnt;
            g.status = ST_OK;
            g.start_slot = 10'(run_start);
            break;
          end
        end
      end
    end else if (idx >= sz || cnt > sz - idx) begin
      g.status = ST_RANGE;
    end else begin
      dbl = 1'b0;
      for (int k = 0; k < cnt; k++) if (free_map[p][idx + k]) dbl = 1'b1;
      if (dbl) begin
        g.status = ST_DOUBLE;
      end else begin
        for (int k = 0; k < cnt; k++) free_map[p][idx + k] = 1'b1;
        used_cnt[p] = (used_cnt[p] >= cnt) ? used_cnt[p] - cnt : 0;
        g.status = ST_OK;
      end
    end
    g.used_slots = 11'(used_cnt[p]);
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  function automatic request_t make_req(logic act, logic [1:0] pool, int idx, int cnt);
    request_t r;
    r.action = act;
    r.heap_select = pool;
    r.slot_index = 10'(idx);
    r.slot_count = 11'(cnt);
    return r;
  endfunction

  // Track live allocations per pool so frees are mostly well formed.
  typedef struct {
    int start;
    int count;
  } run_t;
  run_t live_q [3][$];
  bit   sim_free [3][VIEW_N];

  // Stimulus-side shadow used only to pick sensible frees; the predictor
  // runs at accept time in the monitor.
  function automatic void shadow_apply(request_t r);
    int p, rs, rl, cnt;
    bit ok;
    run_t rr;
    p = r.heap_select;
    cnt = r.slot_count;
    if (p == POOL_BAD || cnt == 0) return;
    if (r.action == ACT_ALLOC) begin
      if (cnt > pool_size[p]) return;
      rl = 0;
      rs = 0;
      for (int i = 0; i < pool_size[p]; i++) begin
        if (sim_free[p][i]) begin
          if (rl == 0) rs = i;
          rl++;
        end else begin
          rl = 0;
        end
        if (rl >= cnt) begin
          for (int k = 0; k < cnt; k++) sim_free[p][rs + k] = 1'b0;
          rr.start = rs;
          rr.count = cnt;
          live_q[p] = {live_q[p], rr};
          return;
        end
      end
    end else begin
      if (r.slot_index >= pool_size[p] || cnt > pool_size[p] - r.slot_index) return;
      ok = 1'b1;
      for (int k = 0; k < cnt; k++) if (sim_free[p][r.slot_index + k]) ok = 1'b0;
      if (ok) for (int k = 0; k < cnt; k++) sim_free[p][r.slot_index + k] = 1'b1;
    end
  endfunction

  function automatic int pick_count(int p);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return 0;
    if (sel == 1) return $urandom_range(0, 2047);
    if (sel == 2) return pool_size[p];
    if (p == 2 && sel < 5) return $urandom_range(1, 256);
    return $urandom_range(1, 12);
  endfunction

  task automatic queue_req(request_t r);
    shadow_apply(r);
    pending_q = {pending_q, r};
  endtask

  initial begin
    request_t r;
    int p, j, kind, s, c;
    for (int q = 0; q < 3; q++) begin
      used_cnt[q] = 0;
      for (int i = 0; i < VIEW_N; i++) begin
        free_map[q][i] = 1'b1;
        sim_free[q][i] = 1'b1;
      end
    end
    // Directed: every error path, both actions, field extremes.
    queue_req(make_req(ACT_ALLOC, POOL_BAD, 1023, 2047));
    queue_req(make_req(ACT_FREE, POOL_BAD, 0, 5));
    queue_req(make_req(ACT_ALLOC, POOL_TARGET, 0, 0));
    queue_req(make_req(ACT_FREE, POOL_DEPTH, 5, 0));
    queue_req(make_req(ACT_ALLOC, POOL_TARGET, 0, 129));
    queue_req(make_req(ACT_ALLOC, POOL_VIEW, 0, 1025));
    queue_req(make_req(ACT_ALLOC, POOL_VIEW, 0, 2047));
    queue_req(make_req(ACT_ALLOC, POOL_TARGET, 1023, 128));
    queue_req(make_req(ACT_ALLOC, POOL_TARGET, 0, 1));
    queue_req(make_req(ACT_FREE, POOL_TARGET, 0, 128));
    queue_req(make_req(ACT_FREE, POOL_TARGET, 128, 1));
    queue_req(make_req(ACT_FREE, POOL_TARGET, 1023, 1));
    queue_req(make_req(ACT_FREE, POOL_TARGET, 100, 29));
    queue_req(make_req(ACT_FREE, POOL_TARGET, 0, 128));
    queue_req(make_req(ACT_ALLOC, POOL_DEPTH, 0, 10));
    queue_req(make_req(ACT_ALLOC, POOL_DEPTH, 0, 5));
    queue_req(make_req(ACT_FREE, POOL_DEPTH, 3, 4));
    queue_req(make_req(ACT_ALLOC, POOL_DEPTH, 0, 4));
    queue_req(make_req(ACT_FREE, POOL_DEPTH, 10, 6));
    queue_req(make_req(ACT_ALLOC, POOL_VIEW, 0, 1024));
    queue_req(make_req(ACT_FREE, POOL_VIEW, 1023, 1));
    queue_req(make_req(ACT_FREE, POOL_VIEW, 0, 1024));
    queue_req(make_req(ACT_FREE, POOL_VIEW, 0, 1023));
    queue_req(make_req(ACT_FREE, POOL_VIEW, 1000, 2047));
    // Random: mostly allocate / exact free of live runs, some partial and junk.
    for (int n = 0; n < N_RANDOM; n++) begin
      p = $urandom_range(0, 2);
      if ($urandom_range(0, 29) == 0) p = POOL_BAD;
      kind = $urandom_range(0, 9);
      if (p == POOL_BAD) begin
        r = make_req(1'($urandom_range(0, 1)), POOL_BAD, $urandom_range(0, 1023),
                     $urandom_range(0, 2047));
      end else if (kind < 4) begin
        r = make_req(ACT_ALLOC, 2'(p), $urandom_range(0, 1023), pick_count(p));
      end else if (kind < 8 && live_q[p].size() > 0) begin
        j = $urandom_range(0, live_q[p].size() - 1);
        s = live_q[p][j].start;
        c = live_q[p][j].count;
        live_q[p].delete(j);
        if (kind == 7 && c > 1) begin
          // Return part of a run; the rest leaks until a wide free hits it.
          s = s + $urandom_range(0, c - 1);
          c = $urandom_range(1, live_q[p].size() + c - (s - s));
          if (s + c > pool_size[p]) c = pool_size[p] - s;
        end
        r = make_req(ACT_FREE, 2'(p), s, c);
      end else if (kind == 8) begin
        r = make_req(ACT_FREE, 2'(p), 0, pool_size[p]);
      end else begin
        r = make_req(ACT_FREE, 2'(p), $urandom_range(0, 1023), pick_count(p));
      end
      queue_req(r);
    end
    stim_done = 1'b1;
  end

  // Reset, then end-of-run check.
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (!(stim_done && pending_q.size() == 0 && !in_valid && grant_q.size() == 0))
      @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_cnt == 0 && grant_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: stops a hung run with a failure message.
  initial begin
    #50ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Driver: hold a transaction until accepted, send in bursts with gaps.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_acc) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_valid <= 1'b1;
          {in_action, in_heap_select, in_slot_index, in_slot_count} <= pending_q.pop_front();
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 15);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      // Receiver stall pattern: long ready stretches, then stall windows.
      rx_phase <= (rx_phase + 1) % 97;
      out_ready <= (rx_phase < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // Monitor: predict on accepted requests, check accepted grants.
  always @(posedge clk) begin
    grant_t got, want;
    in_acc <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready)
        grant_q = {grant_q, allocate_or_release(
          {in_action, in_heap_select, in_slot_index, in_slot_count})};
      if (out_valid && out_ready) begin
        got = {out_status, out_start_slot, out_used_slots};
        if (grant_q.size() == 0) begin
          report_mismatch("unexpected grant status", got.status, -1);
        end else begin
          want = grant_q.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.start_slot !== want.start_slot)
            report_mismatch("start_slot", got.start_slot, want.start_slot);
          if (got.used_slots !== want.used_slots)
            report_mismatch("used_slots", got.used_slots, want.used_slots);
        end
      end
    end
  end

endmodule
